[rtl/mm_pkg.sv]
// Package for the matrix multiply block: payload structs, request and register codes,
// sequencer states and the default dimension limit. No dependencies.
package mm_pkg;

  localparam int MAX_DIM_DEF = 8;

  localparam int VAL_W = 32;
  localparam int FRAC_W = 16;
  localparam int DIM_W = 4;
  localparam int IDX_W = 3;
  localparam int CFG_IDX_W = 2;

  // request codes
  localparam logic [1:0] REQ_WRITE_A = 2'd0;
  localparam logic [1:0] REQ_WRITE_B = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic signed [VAL_W-1:0] element_value;
  } mm_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] result_value;
    logic [IDX_W-1:0] result_row;
    logic [IDX_W-1:0] result_col;
    logic saturated;
    logic last_element;
  } mm_out_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_WB
  } mm_state_t;

endpackage

[rtl/matrix_multiply.sv]
// Top level of the matrix multiply block: A and B element stores, one shared
// multiply-accumulate unit and the sequencer that walks the result. Uses mm_pkg.
//
// A write beat lands in its element store when accepted. A compute beat starts the
// sequencer: per result element the single MAC unit (read, multiply, accumulate stages)
// walks the inner dimension, drains, and the result waits for a free output register.
// in_ready stays low until the last element is loaded, so no request is taken meanwhile.
// Reset (synchronous, active low) sets all dimensions to 8 and clears control state;
// the element stores are not cleared and read back anything until written.
module matrix_multiply
  #(parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF)
  (input  logic                             clk,
   input  logic                             rst_n,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  mm_pkg::mm_in_t                   in_data,
   output logic                             out_valid,
   input  logic                             out_ready,
   output mm_pkg::mm_out_t                  out_data,
   input  logic                             cfg_valid,
   output logic                             cfg_ready,
   input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
   input  logic [mm_pkg::DIM_W-1:0]         cfg_data);

  import mm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(MAX_DIM + 1);
  localparam int ACC_W = 2 * VAL_W + 1 + $clog2(MAX_DIM);
  localparam int SH_W = ACC_W - FRAC_W;

  // configuration registers
  logic [DIM_W-1:0] rows_a_r, inner_dim_r, cols_b_r;

  // sequencer
  mm_state_t state_r, state_nxt;
  logic [CW-1:0] nr_r, nk_r, nc_r, nr_nxt, nk_nxt, nc_nxt;
  logic [CW-1:0] i_r, j_r, k_r, i_nxt, j_nxt, k_nxt;
  logic issue, acc_clr, out_load, last_elem;

  // datapath
  logic signed [VAL_W-1:0] mem_a [DEPTH];
  logic signed [VAL_W-1:0] mem_b [DEPTH];
  logic signed [VAL_W-1:0] a_rd_r, b_rd_r;
  logic signed [2*VAL_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic v1_r, v2_r;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic wr_ok, in_acc;

  logic out_valid_r;
  mm_out_t out_data_r;
  logic [SH_W-1:0] sh;
  logic sat_hi, sat_lo;

  function automatic logic [CW-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return CW'(1);
    end else if (int'(d) > MAX_DIM) begin
      return CW'(MAX_DIM);
    end else begin
      return CW'(d);
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == S_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(8);
      inner_dim_r <= DIM_W'(8);
      cols_b_r <= DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_A: rows_a_r <= cfg_data;
        CFG_INNER_DIM: inner_dim_r <= cfg_data;
        CFG_COLS_B: cols_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // element stores: one write port, one registered read port each
  assign wr_ok = (int'(in_data.row_index) < MAX_DIM) && (int'(in_data.col_index) < MAX_DIM);
  assign wr_addr = AW'(int'(in_data.row_index) * MAX_DIM + int'(in_data.col_index));
  assign rd_addr_a = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign rd_addr_b = AW'(int'(k_r) * MAX_DIM + int'(j_r));

  always_ff @(posedge clk) begin
    if (in_acc && wr_ok && in_data.req_type == REQ_WRITE_A) begin
      mem_a[wr_addr] <= in_data.element_value;
    end
    if (in_acc && wr_ok && in_data.req_type == REQ_WRITE_B) begin
      mem_b[wr_addr] <= in_data.element_value;
    end
    a_rd_r <= mem_a[rd_addr_a];
    b_rd_r <= mem_b[rd_addr_b];
  end

  // MAC pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
    if (acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  // floor shift by the fraction width, then clip to 32 bits
  assign sh = acc_r[ACC_W-1:FRAC_W];
  assign sat_hi = !sh[SH_W-1] && (sh[SH_W-2:VAL_W-1] != '0);
  assign sat_lo = sh[SH_W-1] && (sh[SH_W-2:VAL_W-1] != '1);
  assign last_elem = (i_r == nr_r - CW'(1)) && (j_r == nc_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    nr_nxt = nr_r;
    nk_nxt = nk_r;
    nc_nxt = nc_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    issue = 1'b0;
    acc_clr = 1'b0;
    out_load = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.req_type == REQ_COMPUTE) begin
          nr_nxt = clamp_dim(rows_a_r);
          nk_nxt = clamp_dim(inner_dim_r);
          nc_nxt = clamp_dim(cols_b_r);
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          acc_clr = 1'b1;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        issue = 1'b1;
        if (k_r == nk_r - CW'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + CW'(1);
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          acc_clr = 1'b1;
          k_nxt = '0;
          if (last_elem) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_MAC;
            if (j_r == nc_r - CW'(1)) begin
              j_nxt = '0;
              i_nxt = i_r + CW'(1);
            end else begin
              j_nxt = j_r + CW'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nr_r <= '0;
      nk_r <= '0;
      nc_r <= '0;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
    end else begin
      state_r <= state_nxt;
      nr_r <= nr_nxt;
      nk_r <= nk_nxt;
      nc_r <= nc_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (sat_hi) begin
        out_data_r.result_value <= {1'b0, {(VAL_W-1){1'b1}}};
      end else if (sat_lo) begin
        out_data_r.result_value <= {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
        out_data_r.result_value <= sh[VAL_W-1:0];
      end
      out_data_r.saturated <= sat_hi || sat_lo;
      out_data_r.result_row <= IDX_W'(i_r);
      out_data_r.result_col <= IDX_W'(j_r);
      out_data_r.last_element <= last_elem;
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !v1_r && !v2_r)
    else $error("MAC pipeline busy while sequencer idle");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> k_r < nk_r)
    else $error("inner index past inner dimension");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("pending result overwritten");

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.req_type == REQ_COMPUTE |=> state_r == S_MAC)
    else $error("compute beat did not start the sequencer");

  a_wb_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |-> !v1_r && !v2_r && !issue)
    else $error("writeback with products still in flight");

endmodule

[tb/testbench.sv]
// Self-checking bench for matrix_multiply: loads A and B elements, runs products at several
// dimension settings and checks every result element against an in-bench Q16.16 product.
// Depends on mm_pkg and the matrix_multiply RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int SEGMENT_ITEMS = 2;
  localparam int ACC_W = 72;
  localparam int SLOTS = MAX_DIM_DEF * MAX_DIM_DEF;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // Holds the element stores and dimensions, and the queue of product elements still due.
  class product_board;
    logic signed [VAL_W-1:0] a_elems [SLOTS];
    logic signed [VAL_W-1:0] b_elems [SLOTS];
    logic [DIM_W-1:0] rows_a, inner_dim, cols_b;
    mm_out_t pending [$];
    int errors, checked, clipped;

    function new();
      rows_a = 4'd8;
      inner_dim = 4'd8;
      cols_b = 4'd8;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        CFG_ROWS_A: rows_a = val;
        CFG_INNER_DIM: inner_dim = val;
        CFG_COLS_B: cols_b = val;
        default: ;
      endcase
    endfunction

    // zero reads as one, anything above the store size as the store size
    function int clamp(logic [DIM_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
      return int'(d);
    endfunction

    function void dims(output int nr, output int nk, output int nc);
      nr = clamp(rows_a);
      nk = clamp(inner_dim);
      nc = clamp(cols_b);
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function void push_product();
      int nr, nk, nc;
      logic signed [ACC_W-1:0] acc, wa, wb, q;
      mm_out_t e;
      dims(nr, nk, nc);
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          acc = '0;
          for (int k = 0; k < nk; k++) begin
            wa = a_elems[i * MAX_DIM_DEF + k];
            wb = b_elems[k * MAX_DIM_DEF + j];
            acc = acc + wa * wb;
          end
          // exact Q40.32 sum, arithmetic shift gives the floor
          q = acc >>> FRAC_W;
          e.saturated = (q[ACC_W-1:VAL_W-1] != {(ACC_W - VAL_W + 1){q[ACC_W-1]}});
          if (e.saturated)
            e.result_value = q[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
          else
            e.result_value = q[VAL_W-1:0];
          e.result_row = IDX_W'(i);
          e.result_col = IDX_W'(j);
          e.last_element = (i == nr - 1) && (j == nc - 1);
          pending.push_back(e);
        end
      end
    endfunction

    function void note_request(mm_in_t req);
      case (req.req_type)
        REQ_WRITE_A: a_elems[req.row_index * MAX_DIM_DEF + req.col_index] = req.element_value;
        REQ_WRITE_B: b_elems[req.row_index * MAX_DIM_DEF + req.col_index] = req.element_value;
        REQ_COMPUTE: push_product();
        default: ;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_element(mm_out_t got);
      mm_out_t want;
      if (pending.size() == 0) begin
        report($sformatf("result beat with none due: (%0d,%0d) value %h sat %b last %b",
                         got.result_row, got.result_col, got.result_value, got.saturated,
                         got.last_element));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.saturated) clipped++;
      if (got.result_value !== want.result_value || got.result_row !== want.result_row ||
          got.result_col !== want.result_col || got.saturated !== want.saturated ||
          got.last_element !== want.last_element)
        report($sformatf("mismatch: want (%0d,%0d) %h sat %b last %b, got (%0d,%0d) %h sat %b last %b",
                         want.result_row, want.result_col, want.result_value, want.saturated,
                         want.last_element, got.result_row, got.result_col, got.result_value,
                         got.saturated, got.last_element));
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  mm_in_t in_data;
  mm_out_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0] cfg_data;

  product_board board;
  int send_idle_pct, recv_idle_pct, idle_cycles;
  int requests, computes, settings;
  bit a_set [SLOTS];
  bit b_set [SLOTS];

  matrix_multiply dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_element(out_data);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no beat for %0d cycles, %0d elements still due", idle_cycles,
                 board.outstanding());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic mm_in_t make_item(logic [1:0] kind, int row, int col,
                                       logic [VAL_W-1:0] v);
    mm_in_t it;
    it.req_type = kind;
    it.row_index = IDX_W'(row);
    it.col_index = IDX_W'(col);
    it.element_value = v;
    return it;
  endfunction

  // mostly small magnitudes so sums stay in range; the rest push toward clipping
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          4: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      1, 2: return $urandom;
      3, 4: return $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
      default: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
    endcase
  endfunction

  task automatic send_item(input mm_in_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(item);
    requests++;
    case (item.req_type)
      REQ_WRITE_A: a_set[item.row_index * MAX_DIM_DEF + item.col_index] = 1'b1;
      REQ_WRITE_B: b_set[item.row_index * MAX_DIM_DEF + item.col_index] = 1'b1;
      REQ_COMPUTE: computes++;
      default: ;
    endcase
  endtask

  // load whatever part of A and B the product reads and is still unwritten, then compute
  task automatic send_compute();
    int nr, nk, nc;
    board.dims(nr, nk, nc);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_set[i * MAX_DIM_DEF + k]) send_item(make_item(REQ_WRITE_A, i, k, pick_value()));
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_set[k * MAX_DIM_DEF + j]) send_item(make_item(REQ_WRITE_B, k, j, pick_value()));
    send_item(make_item(REQ_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain all due elements, then give a trailing write beat time to land
  task automatic quiesce();
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_segment(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                             input logic [DIM_W-1:0] c);
    int done;
    int pick;
    quiesce();
    write_reg(CFG_ROWS_A, r);
    write_reg(CFG_INNER_DIM, k);
    write_reg(CFG_COLS_B, c);
    write_reg(CFG_UNMAPPED, DIM_W'($urandom));
    settings++;
    done = 0;
    while (done < SEGMENT_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        send_item(make_item(REQ_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom));
      end else begin
        done++;
        if (pick < 23)
          send_compute();
        else
          send_item(make_item($urandom_range(0, 1) ? REQ_WRITE_A : REQ_WRITE_B,
                              $urandom_range(0, 7), $urandom_range(0, 7), pick_value()));
      end
    end
    send_compute();
  endtask

  initial begin
    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    idle_cycles = 0;
    send_idle_pct = 30;
    recv_idle_pct = 62;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2x2x2 with full-scale operands: every element clips, both directions
    write_reg(CFG_ROWS_A, 4'd2);
    write_reg(CFG_INNER_DIM, 4'd2);
    write_reg(CFG_COLS_B, 4'd2);
    write_reg(CFG_UNMAPPED, 4'hF);
    settings++;
    send_item(make_item(REQ_WRITE_A, 0, 0, 32'h7FFF_FFFF));
    send_item(make_item(REQ_WRITE_A, 0, 1, 32'h7FFF_FFFF));
    send_item(make_item(REQ_WRITE_A, 1, 0, 32'h8000_0000));
    send_item(make_item(REQ_WRITE_A, 1, 1, 32'h0000_0001));
    send_item(make_item(REQ_WRITE_B, 0, 0, 32'h7FFF_FFFF));
    send_item(make_item(REQ_WRITE_B, 1, 0, 32'h7FFF_FFFF));
    send_item(make_item(REQ_WRITE_B, 0, 1, 32'h8000_0000));
    send_item(make_item(REQ_WRITE_B, 1, 1, 32'hFFFF_FFFF));
    // unused request code must leave the stores alone
    send_item(make_item(REQ_UNUSED, 7, 7, 32'h1234_5678));
    send_item(make_item(REQ_COMPUTE, 0, 0, 32'h0000_0000));
    // floor on a negative sub-LSB product, plus unity scaling
    send_item(make_item(REQ_WRITE_A, 0, 0, 32'hFFFF_FFFF));
    send_item(make_item(REQ_WRITE_A, 0, 1, 32'h0000_0000));
    send_item(make_item(REQ_WRITE_B, 0, 0, 32'h0000_0001));
    send_item(make_item(REQ_WRITE_A, 1, 0, 32'h0001_0000));
    send_item(make_item(REQ_WRITE_A, 1, 1, 32'hFFFF_0000));
    send_item(make_item(REQ_WRITE_B, 0, 1, 32'h0003_0000));
    send_item(make_item(REQ_COMPUTE, 7, 7, 32'hFFFF_FFFF));
    send_item(make_item(REQ_WRITE_A, 7, 7, 32'h7FFF_FFFF));
    send_item(make_item(REQ_WRITE_B, 7, 7, 32'h8000_0000));

    run_segment(4'd1, 4'd1, 4'd1);
    run_segment(4'd8, 4'd8, 4'd8);
    send_idle_pct = 62;
    recv_idle_pct = 30;
    run_segment(4'd0, 4'd15, 4'd9);
    run_segment(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)),
                DIM_W'($urandom_range(0, 15)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(DIM_W'($urandom_range(0, 15)), DIM_W'($urandom_range(0, 15)),
                DIM_W'($urandom_range(0, 15)));
    run_segment(4'd8, 4'd1, 4'd8);
    quiesce();

    $display("Sent %0d request beats (%0d products) over %0d dimension settings",
             requests, computes, settings);
    $display("Compared %0d result elements, %0d of them clipped; %0d failures",
             board.checked, board.clipped, board.errors);
    if (board.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

[files.f]
rtl/mm_pkg.sv
rtl/matrix_multiply.sv
tb/testbench.sv
